// File: src/tvrs_pkg.sv
// shared types and constants for the typed value range scanner
// no dependencies
package tvrs_pkg;

    localparam int OFFSET_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        TYPE_INT16   = 3'd0,
        TYPE_INT32   = 3'd1,
        TYPE_INT64   = 3'd2,
        TYPE_FLOAT32 = 3'd3,
        TYPE_FLOAT64 = 3'd4
    } value_type_t;

    typedef enum logic [1:0] {
        REG_VALUE_TYPE = 2'd0,
        REG_LOW_BOUND  = 2'd1,
        REG_HIGH_BOUND = 2'd2
    } reg_index_t;

    // view of one window position: valid flag, value bits and byte size
    typedef struct packed {
        logic        valid;
        logic [63:0] bits;
        logic [3:0]  size;
    } cand_t;

    // signed or ieee compare a <= b on 64 bits, mode given by the flt flag
    function automatic logic le64(input logic [63:0] a, input logic [63:0] b, input logic flt);
        logic sa;
        logic sb;
        logic a_zero;
        logic b_zero;
        logic res;
        sa = a[63];
        sb = b[63];
        a_zero = (a[62:0] == 63'd0);
        b_zero = (b[62:0] == 63'd0);
        if (!flt) begin
            res = ($signed(a) <= $signed(b));
        end else if (a_zero && b_zero) begin
            res = 1'b1;
        end else if (sa != sb) begin
            res = sa;
        end else if (!sa) begin
            res = (a[62:0] <= b[62:0]);
        end else begin
            res = (a[62:0] >= b[62:0]);
        end
        return res;
    endfunction

endpackage

// File: src/tvrs_stream_if.sv
// valid / ready channel interface with a generic payload
// depends on nothing
interface tvrs_stream_if #(parameter int WIDTH = 8);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: src/typed_value_range_scanner.sv
// top level of the typed value range scanner
// depends on tvrs_pkg, tvrs_stream_if, tvrs_window, tvrs_compare
//
// usage:
//   in channel carries {restart, data_byte}; restart marks byte offset zero.
//   out channel carries {match_offset, match_bits} for each byte whose
//   completed value of the configured type lies in [low_bound, high_bound].
//   configuration: cfg_we, cfg_index, cfg_data; write only while idle.
//   throughput: one byte per cycle while no result stalls; the window shift and both comparators
//   sit between the input and the result register.
//   latency: a match is presented in the cycle after its last byte is taken.
//   stall: the single result register holds until taken; a new byte is
//   taken whenever the result register is empty or drained that cycle.
//   reset clears window, offset, fill count, registers and the result valid.
module typed_value_range_scanner
    import tvrs_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    tvrs_stream_if.sink   in_ch,
    tvrs_stream_if.source out_ch
);
    logic [2:0]  type_reg;
    logic [63:0] low_reg, high_reg;
    logic        take;
    logic [63:0] window, bits;
    logic [3:0]  fill, size;
    logic        hit;
    logic [OFFSET_WIDTH-1:0] here, start;
    logic        valid_reg;
    logic [95:0] out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg <= '0; low_reg <= '0; high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VALUE_TYPE: type_reg <= cfg_data[2:0];
                REG_LOW_BOUND:  low_reg  <= cfg_data;
                REG_HIGH_BOUND: high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ch.ready = !valid_reg || out_ch.ready;
    assign take = in_ch.valid && in_ch.ready;

    tvrs_window #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_window (
        .clk(clk), .rst_n(rst_n), .take(take),
        .data_byte(in_ch.payload[7:0]), .restart(in_ch.payload[8]),
        .window(window), .fill(fill), .here(here)
    );

    tvrs_compare u_compare (
        .value_type(type_reg), .low_bound(low_reg), .high_bound(high_reg),
        .window(window), .fill(fill), .hit(hit), .bits(bits), .size(size)
    );

    assign start = here - OFFSET_WIDTH'(size - 4'd1);

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ch.ready)
            valid_reg <= take && hit;
    end

    always_ff @(posedge clk)
    begin
        if (take && hit)
            out_reg <= {32'(64'(start)), bits};
    end

    assign out_ch.valid   = valid_reg;
    assign out_ch.payload = out_reg;

    // a pending result is never dropped by a new byte
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ch.ready |=> valid_reg && $stable(out_reg))
        else $error("result lost under stall");
    // no byte is taken while a result stalls
    a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ch.ready |-> !take)
        else $error("byte taken during stall");
    // a result appears only after a byte
    a_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> $past(take))
        else $error("result without byte");
endmodule

// File: src/tvrs_window.sv
// byte window, offset counter and fill count
// depends on tvrs_pkg
module tvrs_window
    import tvrs_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    take,
    input  logic [7:0]              data_byte,
    input  logic                    restart,
    output logic [63:0]             window,
    output logic [3:0]              fill,
    output logic [OFFSET_WIDTH-1:0] here
);
    logic [63:0]             window_reg, window_next;
    logic [3:0]              fill_reg, fill_next;
    logic [OFFSET_WIDTH-1:0] offset_reg, offset_next;
    logic [OFFSET_WIDTH-1:0] here_next;

    // newest byte enters at the top
    always_comb
    begin
        window_next = restart ? {data_byte, 56'd0} : {data_byte, window_reg[63:8]};
        fill_next   = restart ? 4'd1 : ((fill_reg < 4'd8) ? fill_reg + 4'd1 : fill_reg);
        here_next   = restart ? '0 : offset_reg;
        offset_next = here_next + {{(OFFSET_WIDTH-1){1'b0}}, 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
            offset_reg <= '0;
        end
        else if (take)
        begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
            offset_reg <= offset_next;
        end
    end

    assign window = window_next;
    assign fill   = fill_next;
    assign here   = here_next;
endmodule

// File: src/tvrs_compare.sv
// range test of the assembled value against the bounds
// depends on tvrs_pkg
module tvrs_compare
    import tvrs_pkg::*;
(
    input  logic [2:0]  value_type,
    input  logic [63:0] low_bound,
    input  logic [63:0] high_bound,
    input  logic [63:0] window,
    input  logic [3:0]  fill,
    output logic        hit,
    output logic [63:0] bits,
    output logic [3:0]  size
);
    logic [63:0] x, lo, hi;
    logic        flt, nan;

    // place value and bounds in the top bits so one 64-bit compare serves all
    always_comb
    begin
        x = '0; lo = '0; hi = '0; flt = 1'b0; nan = 1'b0; bits = '0; size = 4'd0;
        unique case (value_type)
            TYPE_INT16:
            begin
                size = 4'd2; bits = {48'd0, window[63:48]};
                x = {window[63:48], 48'd0};
                lo = {low_bound[15:0], 48'd0}; hi = {high_bound[15:0], 48'd0};
            end
            TYPE_INT32, TYPE_FLOAT32:
            begin
                size = 4'd4; bits = {32'd0, window[63:32]};
                x = {window[63:32], 32'd0};
                lo = {low_bound[31:0], 32'd0}; hi = {high_bound[31:0], 32'd0};
                flt = (value_type == TYPE_FLOAT32);
                nan = flt && ((&x[62:55] && x[54:32] != 0) || (&lo[62:55] && lo[54:32] != 0)
                    || (&hi[62:55] && hi[54:32] != 0));
            end
            TYPE_INT64, TYPE_FLOAT64:
            begin
                size = 4'd8; bits = window;
                x = window; lo = low_bound; hi = high_bound;
                flt = (value_type == TYPE_FLOAT64);
                nan = flt && ((&x[62:52] && x[51:0] != 0) || (&lo[62:52] && lo[51:0] != 0)
                    || (&hi[62:52] && hi[51:0] != 0));
            end
            default: size = 4'd0;
        endcase
        hit = (size != 4'd0) && (fill >= size) && !nan && le64(lo, x, flt) && le64(x, hi, flt);
    end
endmodule
